FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// immediate relation checked on every clock edge outside reset
`define CFIR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("cfir assertion failed");

// antecedent on this edge implies consequent on the next edge
`define CFIR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfir assertion failed");

`endif

FILE: design/cfir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfir_pkg;

  // filter geometry
  localparam int TAPS            = 16;
  localparam int SAMPLE_W        = 16;
  localparam int PROD_W          = 2 * SAMPLE_W;
  localparam int ACC_W           = PROD_W + $clog2(TAPS);
  localparam int SHIFT_W         = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int NUM_COEF_REGS   = 4;
  localparam int WEIGHTS_PER_REG = CFG_DATA_W / SAMPLE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT = CFG_IDX_W'(4);

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(15);

  // one complex sample, real part in the low half
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] im;
    logic signed [SAMPLE_W-1:0] re;
  } sample_t;

  // partial sum travelling along the cell row
  typedef struct packed {
    logic                    valid;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } acc_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       clip;
  } sat_t;

  // floor shift then saturate to the sample width
  function automatic sat_t shift_sat(logic signed [ACC_W-1:0] acc,
                                     logic [SHIFT_W-1:0] sh);
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] max_v;
    logic signed [ACC_W-1:0] min_v;
    sat_t                    res;
    q     = acc >>> sh;
    max_v = ACC_W'($signed({1'b0, {(SAMPLE_W-1){1'b1}}}));
    min_v = ACC_W'($signed({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (q > max_v) begin
      res.value = max_v[SAMPLE_W-1:0];
      res.clip  = 1'b1;
    end else if (q < min_v) begin
      res.value = min_v[SAMPLE_W-1:0];
      res.clip  = 1'b1;
    end else begin
      res.value = q[SAMPLE_W-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/complex_fir_filter.sv
// Complex FIR filter with real Q1.15 weights over a 16-entry delay line.
// Input channel: in_valid_i / in_stall_o with sample_re_i, sample_im_i; a
// request is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with filtered_re_o,
// filtered_im_o and saturated_o; one result per input request.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects the
// register (0..3 weights, 4 output shift), cfg_data_i carries the value;
// ready is always high, write only while the filter is idle.
// One request is processed at a time: the partial sum walks the row of
// TAPS cells one cell per cycle, and a result passes start_q, start2_q,
// the cells and the holding register before the output register; the next
// request is taken only once that result has moved into the output register.
// Reset clears the delay line and weights to zero and sets the shift to 15.
// A stalled output holds its result; the finished result of the next request
// waits in a holding register and input stays stalled until it moves out.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module complex_fir_filter (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_re_i,
  input  wire logic signed [cfir_pkg::SAMPLE_W-1:0]   sample_im_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [cfir_pkg::SAMPLE_W-1:0]        filtered_re_o,
  output logic signed [cfir_pkg::SAMPLE_W-1:0]        filtered_im_o,
  output logic                                        saturated_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [cfir_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [cfir_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic [cfir_pkg::CFG_DATA_W-1:0]     coef_q [cfir_pkg::NUM_COEF_REGS];
  logic [cfir_pkg::SHIFT_W-1:0]        shift_q;
  logic                                busy_q;
  logic                                start_q;
  logic                                start2_q;
  logic                                res_valid_q;
  logic signed [cfir_pkg::ACC_W-1:0]   res_re_q;
  logic signed [cfir_pkg::ACC_W-1:0]   res_im_q;
  logic                                out_valid_q;
  logic signed [cfir_pkg::SAMPLE_W-1:0] out_re_q;
  logic signed [cfir_pkg::SAMPLE_W-1:0] out_im_q;
  logic                                out_sat_q;
  logic                                accept;
  logic                                out_load;
  logic                                cfg_write;
  cfir_pkg::sample_t                   samp_chain [cfir_pkg::TAPS+1];
  cfir_pkg::acc_t                      acc_chain  [cfir_pkg::TAPS+1];
  logic [cfir_pkg::TAPS-1:0]           tok_vec;
  cfir_pkg::sat_t                      sat_re;
  cfir_pkg::sat_t                      sat_im;
  logic                                rail_hit;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_write  = cfg_valid_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cfir_pkg::NUM_COEF_REGS; i++) begin
        coef_q[i] <= '0;
      end
      shift_q <= cfir_pkg::SHIFT_RESET;
    end else if (cfg_write) begin
      case (cfg_index_i)
        cfir_pkg::REG_COEF_0:    coef_q[0] <= cfg_data_i;
        cfir_pkg::REG_COEF_1:    coef_q[1] <= cfg_data_i;
        cfir_pkg::REG_COEF_2:    coef_q[2] <= cfg_data_i;
        cfir_pkg::REG_COEF_3:    coef_q[3] <= cfg_data_i;
        cfir_pkg::REG_OUT_SHIFT: shift_q   <= cfg_data_i[cfir_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // new sample enters the row, sum token starts once products settle
  assign samp_chain[0].re = sample_re_i;
  assign samp_chain[0].im = sample_im_i;
  assign acc_chain[0].valid = start2_q;
  assign acc_chain[0].re    = '0;
  assign acc_chain[0].im    = '0;

  // row of tap cells
  for (genvar k = 0; k < cfir_pkg::TAPS; k++) begin : g_cell
    cfir_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (accept),
      .sample_i   (samp_chain[k]),
      .weight_i   ($signed(coef_q[k / cfir_pkg::WEIGHTS_PER_REG]
                     [(k % cfir_pkg::WEIGHTS_PER_REG) * cfir_pkg::SAMPLE_W +:
                      cfir_pkg::SAMPLE_W])),
      .acc_i      (acc_chain[k]),
      .sample_o   (samp_chain[k+1]),
      .acc_o      (acc_chain[k+1])
    );
    assign tok_vec[k] = acc_chain[k+1].valid;
  end

  // scaling of the held sum
  assign sat_re   = cfir_pkg::shift_sat(res_re_q, shift_q);
  assign sat_im   = cfir_pkg::shift_sat(res_im_q, shift_q);
  assign out_load = res_valid_q && (!out_valid_q || !out_stall_i);

  // request sequencing, holding register and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      start2_q    <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q  <= accept;
      start2_q <= start_q;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (acc_chain[cfir_pkg::TAPS].valid) begin
        res_valid_q <= 1'b1;
      end else if (out_load) begin
        res_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (acc_chain[cfir_pkg::TAPS].valid) begin
      res_re_q <= acc_chain[cfir_pkg::TAPS].re;
      res_im_q <= acc_chain[cfir_pkg::TAPS].im;
    end
    if (out_load) begin
      out_re_q  <= sat_re.value;
      out_im_q  <= sat_im.value;
      out_sat_q <= sat_re.clip || sat_im.clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filtered_re_o = out_re_q;
  assign filtered_im_o = out_im_q;
  assign saturated_o   = out_sat_q;

  // output part sits at either rail
  assign rail_hit = out_re_q == 16'sh7fff || out_re_q == 16'sh8000 ||
                    out_im_q == 16'sh7fff || out_im_q == 16'sh8000;

  // at most one partial sum in flight along the row
  `CFIR_ASSERT(a_one_token, $onehot0({tok_vec, start_q, start2_q, res_valid_q}))
  // nothing in flight while idle
  `CFIR_ASSERT(a_idle_empty, !busy_q |-> (tok_vec == '0 && !start_q && !start2_q && !res_valid_q))
  // a taken request sets start_q and busy_q on the following edge
  `CFIR_ASSERT_NEXT(a_start, accept, start_q && busy_q)
  // a clipped result sits at a rail
  `CFIR_ASSERT(a_sat_rail, (out_valid_q && out_sat_q) |-> rail_hit)

endmodule

`default_nettype wire

FILE: design/cfir_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cfir_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              shift_en_i,
  input  wire cfir_pkg::sample_t                 sample_i,
  input  wire logic signed [cfir_pkg::SAMPLE_W-1:0] weight_i,
  input  wire cfir_pkg::acc_t                    acc_i,
  output cfir_pkg::sample_t                      sample_o,
  output cfir_pkg::acc_t                         acc_o
);

  cfir_pkg::sample_t                       sample_q;
  logic signed [cfir_pkg::PROD_W-1:0]      prod_re_q;
  logic signed [cfir_pkg::PROD_W-1:0]      prod_im_q;
  logic                                    acc_valid_q;
  logic signed [cfir_pkg::ACC_W-1:0]       acc_re_q;
  logic signed [cfir_pkg::ACC_W-1:0]       acc_im_q;

  // delay line tap, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_en_i) begin
      sample_q <= sample_i;
    end
  end

  // weighted tap, registered every cycle
  always_ff @(posedge clk_i) begin
    prod_re_q <= weight_i * sample_q.re;
    prod_im_q <= weight_i * sample_q.im;
  end

  // partial sum token moves one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else begin
      acc_valid_q <= acc_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_i.re + cfir_pkg::ACC_W'(prod_re_q);
    acc_im_q <= acc_i.im + cfir_pkg::ACC_W'(prod_im_q);
  end

  assign sample_o    = sample_q;
  assign acc_o.valid = acc_valid_q;
  assign acc_o.re    = acc_re_q;
  assign acc_o.im    = acc_im_q;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cfir_pkg::*;

  localparam int FILL_CYCLES     = TAPS + 4;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int MAX_REPORTS     = 100;
  localparam int BANK_W          = NUM_COEF_REGS * CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] LAST_INDEX = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       clip;
  } filter_out_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic signed [SAMPLE_W-1:0]   sample_re_i = '0;
  logic signed [SAMPLE_W-1:0]   sample_im_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   filtered_re_o;
  logic signed [SAMPLE_W-1:0]   filtered_im_o;
  logic                         saturated_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i  = '0;

  // filter shadow: weights, shift and delay line as the block should hold them
  logic [CFG_DATA_W-1:0]        weight_bank [NUM_COEF_REGS] = '{default: '0};
  logic [SHIFT_W-1:0]           sum_shift = SHIFT_RESET;
  logic signed [SAMPLE_W-1:0]   hist_re [TAPS] = '{default: '0};
  logic signed [SAMPLE_W-1:0]   hist_im [TAPS] = '{default: '0};

  filter_out_t                  pending_outputs [$];
  int                           mismatch_count = 0;
  int                           quiet_cycles   = 0;
  int                           holdoff_left   = 0;
  bit                           gaps_on        = 1'b1;
  bit                           holdoff_kick   = 1'b0;

  complex_fir_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .filtered_re_o (filtered_re_o),
    .filtered_im_o (filtered_im_o),
    .saturated_o   (saturated_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // clip a floored sum to the sample range, clip flag on top
  function automatic logic [SAMPLE_W:0] clamp_sample(longint q);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (q > hi) return {1'b1, hi[SAMPLE_W-1:0]};
    if (q < lo) return {1'b1, lo[SAMPLE_W-1:0]};
    return {1'b0, q[SAMPLE_W-1:0]};
  endfunction

  // shift the new sample in and form the filtered output
  function automatic filter_out_t fir_predict(logic signed [SAMPLE_W-1:0] re,
                                              logic signed [SAMPLE_W-1:0] im);
    longint                     acc_re;
    longint                     acc_im;
    logic signed [SAMPLE_W-1:0] w;
    logic [SAMPLE_W:0]          cr;
    logic [SAMPLE_W:0]          ci;
    filter_out_t                res;
    for (int k = TAPS - 1; k > 0; k--) begin
      hist_re[k] = hist_re[k-1];
      hist_im[k] = hist_im[k-1];
    end
    hist_re[0] = re;
    hist_im[0] = im;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < TAPS; k++) begin
      w = weight_bank[k / WEIGHTS_PER_REG][(k % WEIGHTS_PER_REG) * SAMPLE_W +: SAMPLE_W];
      acc_re += longint'(w) * longint'(hist_re[k]);
      acc_im += longint'(w) * longint'(hist_im[k]);
    end
    cr = clamp_sample(acc_re >>> sum_shift);
    ci = clamp_sample(acc_im >>> sum_shift);
    res.re   = cr[SAMPLE_W-1:0];
    res.im   = ci[SAMPLE_W-1:0];
    res.clip = cr[SAMPLE_W] | ci[SAMPLE_W];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: %s got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    filter_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result with nothing pending, filtered_re", filtered_re_o, 0);
      end else begin
        want = pending_outputs.pop_front();
        if (filtered_re_o !== want.re) report_mismatch("filtered_re", filtered_re_o, want.re);
        if (filtered_im_o !== want.im) report_mismatch("filtered_im", filtered_im_o, want.im);
        if (saturated_o !== want.clip) report_mismatch("saturated", saturated_o, want.clip);
      end
    end
  end

  // watchdog on cycles without any input, output or config handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk_i) begin
    if (holdoff_kick) begin
      holdoff_kick = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= gaps_on && ($urandom_range(0, 99) < 20);
    end
  end

  // one sample request; valid stays high on return
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                             input logic signed [SAMPLE_W-1:0] im);
    if (gaps_on && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, FILL_CYCLES + 4)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_outputs.push_back(fir_predict(re, im));
    @(negedge clk_i);
  endtask

  // stop input and let every pending result come out
  task automatic finish_batch();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    repeat (FILL_CYCLES) @(negedge clk_i);
  endtask

  // one register write request; valid stays high on return
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3:
        weight_bank[idx[$clog2(NUM_COEF_REGS)-1:0]] = data;
      REG_OUT_SHIFT: sum_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_setting(input logic [BANK_W-1:0] weights,
                              input logic [SHIFT_W-1:0] shift);
    logic [CFG_DATA_W-1:0] junk;
    finish_batch();
    for (int i = 0; i < NUM_COEF_REGS; i++)
      write_reg(CFG_IDX_W'(REG_COEF_0 + i), weights[i*CFG_DATA_W +: CFG_DATA_W]);
    // upper bits of the shift write carry junk
    junk = {$urandom, $urandom};
    write_reg(REG_OUT_SHIFT, {junk[CFG_DATA_W-1:SHIFT_W], shift});
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [BANK_W-1:0] random_weights();
    logic [BANK_W-1:0] bank;
    logic              small_taps;
    small_taps = 1'($urandom_range(0, 1));
    for (int k = 0; k < TAPS; k++) begin
      bank[k*SAMPLE_W +: SAMPLE_W] = small_taps ?
          SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096) : SAMPLE_W'($urandom);
    end
    return bank;
  endfunction

  function automatic logic [SHIFT_W-1:0] random_shift();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SHIFT_W'($urandom_range(12, 18));
    endcase
  endfunction

  // zero weights after reset give zero output
  task automatic test_reset_defaults();
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
  endtask

  // tap 0 near unity, default shift
  task automatic test_passthrough();
    load_setting(BANK_W'(16'h7fff), SHIFT_RESET);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd1, -16'sd1);
  endtask

  // most negative weights everywhere, no shift then the largest shift
  task automatic test_shift_extremes();
    logic [BANK_W-1:0] all_min;
    all_min = {(TAPS){16'h8000}};
    load_setting(all_min, '0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh0000, -16'sd1);
    load_setting(all_min, '1);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sh8000, 16'sh8000);
  endtask

  // writes above the shift register must leave everything as it was
  task automatic test_bad_index();
    load_setting(random_weights(), SHIFT_W'(14));
    for (int idx = REG_OUT_SHIFT + 1; idx <= LAST_INDEX; idx++)
      write_reg(CFG_IDX_W'(idx), '1);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    repeat (4) send_sample(random_sample(), random_sample());
  endtask

  task automatic test_random_settings();
    repeat (5) begin
      load_setting(random_weights(), random_shift());
      repeat (200) send_sample(random_sample(), random_sample());
    end
  endtask

  task automatic test_real_stream();
    load_setting(random_weights(), random_shift());
    repeat (100) send_sample(random_sample(), '0);
  endtask

  // back-to-back requests with neither side idling
  task automatic test_steady_stream();
    load_setting(random_weights(), SHIFT_W'(16));
    gaps_on = 1'b0;
    repeat (200) send_sample(random_sample(), random_sample());
    finish_batch();
    gaps_on = 1'b1;
  endtask

  // receiver holds off while samples keep coming, so the input backs up
  task automatic test_backpressure();
    load_setting(random_weights(), random_shift());
    holdoff_kick = 1'b1;
    repeat (150) send_sample(random_sample(), random_sample());
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_passthrough();
    test_shift_extremes();
    test_bad_index();
    test_random_settings();
    test_real_stream();
    test_steady_stream();
    test_backpressure();
    finish_batch();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/cfir_pkg.sv
design/cfir_cell.sv
design/complex_fir_filter.sv
tb/testbench.sv
